// ===== design/omv_pkg.sv =====
// ----------------------------------------------------------------------------
// omv_pkg: shared types and constants for the online mean/variance unit
// Word formats, fixed widths and the divider control/status bundles.
// ----------------------------------------------------------------------------
package omv_pkg;

  // Sample and mean: two's complement, 16 fraction bits.
  localparam int unsigned SampleW = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned FracW   = 16;
  // Sum of squared deviations, unsigned, 16 fraction bits.
  localparam int unsigned M2W     = 64;
  localparam int unsigned VarW    = 63;
  // x - mean needs one extra bit.
  localparam int unsigned DiffW   = SampleW + 1;
  localparam int unsigned ProdW   = 2 * DiffW;
  // Divider dividend width and iteration counter width.
  localparam int unsigned DvdW    = M2W;
  localparam int unsigned IterW   = $clog2(DvdW + 1);

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] mean;
    logic [VarW-1:0]           variance;
    logic [CountW-1:0]         sample_count;
    logic                      variance_valid;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [DvdW-1:0]   dividend;
    logic [CountW-1:0] divisor;
    logic [IterW-1:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic            last_step;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/omv_div.sv =====
// ----------------------------------------------------------------------------
// omv_div: shared restoring divider
// One quotient bit per cycle, MSB first; iteration count set at start.
// ----------------------------------------------------------------------------
module omv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  omv_pkg::div_req_t req_i,
  output omv_pkg::div_rsp_t rsp_o
);

  logic [omv_pkg::IterW-1:0]  cnt_q, cnt_d;
  logic [omv_pkg::CountW-1:0] rem_q, rem_d;
  logic [omv_pkg::CountW-1:0] dvs_q;
  logic [omv_pkg::DvdW-1:0]   quo_q;
  logic [omv_pkg::CountW:0]   cand;
  logic [omv_pkg::CountW:0]   cand_sub;
  logic                       ge;

  // Partial remainder shifted left with the next dividend bit.
  always_comb begin
    cand     = {rem_q, quo_q[omv_pkg::DvdW-1]};
    cand_sub = cand - {1'b0, dvs_q};
    ge       = (cand >= {1'b0, dvs_q});
    rem_d    = ge ? cand_sub[omv_pkg::CountW-1:0] : cand[omv_pkg::CountW-1:0];
  end

  always_comb begin
    if (req_i.start) begin
      cnt_d = req_i.iters;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Quotient bits shift in where dividend bits leave.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[omv_pkg::DvdW-2:0], ge};
    end
  end

  assign rsp_o.last_step = (cnt_q == omv_pkg::IterW'(1));
  assign rsp_o.quotient  = quo_q;

endmodule

// ===== design/online_mean_variance_unit.sv =====
// ----------------------------------------------------------------------------
// online_mean_variance_unit: running mean and sample variance (Welford)
// Per sample: n++, d = x - mean, mean += d/n, M2 += d*(x - mean) >> 16.
// On the last sample of a set: emit mean, M2/(n-1) (0 if n = 1), n; clear the state.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall        | word
//  --------+-------------+--------------+-----------------------------
//  in      | in_valid_i  | in_stall_o   | in_data_i  (sample, last)
//  out     | out_valid_o | out_stall_i  | out_data_o (mean, variance,
//          |             |              |   sample_count, variance_valid)
//
//  Steps per sample: accept, divider start, the divide steps for d/n,
//    mean update, multiply, M2 accumulate. The last sample of a set of two
//    or more adds a divider start, the divide steps for M2/(n-1) and the
//    result load; a lone sample adds only the result load.
//    The shared divider produces one quotient bit per cycle.
//  in_stall_o is high from the cycle after an accept until the block is idle.
//  The result sits in an output register; the next sample is taken while it
//    waits. A new result waits in the final state until that register frees.
//  Reset clears count, mean, M2 and the output valid.
//
module online_mean_variance_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  omv_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output omv_pkg::out_word_t out_data_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DSTART = 4'd1;  // kick off d/n
  localparam logic [3:0] S_DWAIT  = 4'd2;
  localparam logic [3:0] S_MEAN   = 4'd3;  // mean += q
  localparam logic [3:0] S_MUL    = 4'd4;  // |d| * |x - mean|
  localparam logic [3:0] S_ACC    = 4'd5;  // M2 += prod >> 16, saturating
  localparam logic [3:0] S_VSTART = 4'd6;  // kick off M2/(n-1)
  localparam logic [3:0] S_VWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;  // load output register, clear

  localparam int unsigned SampleW = omv_pkg::SampleW;
  localparam int unsigned CountW  = omv_pkg::CountW;
  localparam int unsigned DiffW   = omv_pkg::DiffW;
  localparam int unsigned ProdW   = omv_pkg::ProdW;
  localparam int unsigned M2W     = omv_pkg::M2W;
  localparam int unsigned VarW    = omv_pkg::VarW;
  localparam int unsigned DvdW    = omv_pkg::DvdW;

  logic [3:0]         state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [SampleW-1:0] mean_q, mean_d;
  logic [M2W-1:0]     m2_q, m2_d;
  logic               out_valid_q, out_valid_d;

  // Per-sample working registers (no reset needed)
  logic [SampleW-1:0] x_q;
  logic [DiffW-1:0]   dmag_q;
  logic               dneg_q;
  logic               last_q;
  logic [ProdW-1:0]   prod_q;
  omv_pkg::out_word_t out_q;

  logic               in_acc;
  logic               out_load;
  logic [SampleW-1:0] sub_x;
  logic [DiffW-1:0]   diff;
  logic [DiffW-1:0]   diff_mag;
  logic [DiffW-1:0]   q;
  logic [DiffW-1:0]   q_signed;
  logic [DiffW-1:0]   mean_sum;
  logic [M2W:0]       m2_sum;
  logic [CountW-1:0]  count_inc;
  logic [VarW-1:0]    var_sat;
  logic               cnt_ge2;

  omv_pkg::div_req_t  div_req;
  omv_pkg::div_rsp_t  div_rsp;

  omv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // One subtractor: x - mean for the new sample at accept, x - new mean later.
  always_comb begin
    sub_x    = (state_q == S_IDLE) ? in_data_i.sample : x_q;
    diff     = {sub_x[SampleW-1], sub_x} - {mean_q[SampleW-1], mean_q};
    diff_mag = diff[DiffW-1] ? (~diff + DiffW'(1)) : diff;
  end

  // Mean update: quotient truncates toward zero, sign from d.
  always_comb begin
    q        = div_rsp.quotient[DiffW-1:0];
    q_signed = dneg_q ? (~q + DiffW'(1)) : q;
    mean_sum = {mean_q[SampleW-1], mean_q} + q_signed;
  end

  assign m2_sum    = {1'b0, m2_q} + (M2W + 1)'(prod_q >> omv_pkg::FracW);
  assign count_inc = (&count_q) ? count_q : count_q + 1'b1;
  assign cnt_ge2   = (count_q >= CountW'(2));
  // Only a divisor of one can push the quotient past the variance range.
  assign var_sat   = (|div_rsp.quotient[DvdW-1:VarW]) ? {VarW{1'b1}}
                                                      : div_rsp.quotient[VarW-1:0];

  always_comb begin
    div_req.start    = state_q inside {S_DSTART, S_VSTART};
    div_req.dividend = (state_q == S_DSTART) ? {dmag_q, {(DvdW - DiffW){1'b0}}} : m2_q;
    div_req.divisor  = (state_q == S_DSTART) ? count_q : count_q - 1'b1;
    div_req.iters    = (state_q == S_DSTART) ? omv_pkg::IterW'(DiffW)
                                             : omv_pkg::IterW'(DvdW);
  end

  // Sequencer and running state
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mean_d      = mean_q;
    m2_d        = m2_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          count_d = count_inc;
          state_d = S_DSTART;
        end
      end
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.last_step) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        mean_d  = mean_sum[SampleW-1:0];
        state_d = S_MUL;
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        m2_d = m2_sum[M2W] ? {M2W{1'b1}} : m2_sum[M2W-1:0];
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (cnt_ge2) begin
          state_d = S_VSTART;
        end else begin
          state_d = S_OUT;
        end
      end
      S_VSTART: state_d = S_VWAIT;
      S_VWAIT: begin
        if (div_rsp.last_step) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          count_d     = '0;
          mean_d      = '0;
          m2_d        = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mean_q      <= mean_d;
      m2_q        <= m2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= in_data_i.sample;
      last_q <= in_data_i.last;
      dmag_q <= diff_mag;
      dneg_q <= diff[DiffW-1];
    end
    // |d| * |x - new mean|, never negative
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(dmag_q) * ProdW'(diff_mag);
    end
    if (out_load) begin
      out_q.mean           <= mean_q;
      out_q.variance       <= cnt_ge2 ? var_sat : '0;
      out_q.sample_count   <= count_q;
      out_q.variance_valid <= cnt_ge2;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/omv_checker.sv =====
// ----------------------------------------------------------------------------
// omv_checker: port-level checks for the online mean/variance unit
// Watches the handshakes and result consistency; attached by bind.
// ----------------------------------------------------------------------------
module omv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input omv_pkg::in_word_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input omv_pkg::out_word_t out_data_o
);

  // One sample at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is still in work");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // Variance flag follows the count; no variance without it.
  a_var_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.variance_valid
                     ? (out_data_o.sample_count >= omv_pkg::CountW'(2))
                     : (out_data_o.sample_count == omv_pkg::CountW'(1)
                        && out_data_o.variance == '0)))
    else $error("variance flag inconsistent with count");

  // A new result only appears at the end of work on a sample.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a sample in work");

endmodule

bind online_mean_variance_unit omv_checker u_omv_checker (.*);
